>>> rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address-resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEFAULT_ENTRIES = 8;
    localparam int MAX_ENTRIES     = 64;
    localparam int SLOT_W          = $clog2(MAX_ENTRIES);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 48;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_SLOT_W = 3;

    localparam logic [CFG_W-1:0] LIFETIME_RST = 32'd60000;
    localparam logic [CFG_W-1:0] RETRY_RST    = 32'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 2'd1;

    // request kinds
    localparam logic REQ_RESOLVE = 1'b0;
    localparam logic REQ_LEARN   = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [IP_W-1:0]   ip_addr;
        logic [MAC_W-1:0]  mac_addr;
        logic [TIME_W-1:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic                  hit;
        logic [MAC_W-1:0]      mac_out;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  send_request;
    } t_out_rsp;

    // search state handed from cell to cell; oldest carries one extra bit
    // so the start value sits above every real stamp
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W:0]   oldest;
    } t_carry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } t_wr;

endpackage

>>> rtl/core/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
module arpc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arpc_pkg::t_in_req              i_req,
    input  logic [arpc_pkg::CFG_W-1:0]     i_lifetime,
    input  arpc_pkg::t_carry               i_carry,
    output arpc_pkg::t_carry               o_carry,
    input  arpc_pkg::t_wr                  i_wr
);

    logic                             r_valid;
    logic [arpc_pkg::IP_W-1:0]        r_ip;
    logic [arpc_pkg::MAC_W-1:0]       r_mac;
    logic [arpc_pkg::TIME_W-1:0]      r_stamp;
    arpc_pkg::t_carry                 r_carry;
    arpc_pkg::t_carry                 n_carry;

    logic [arpc_pkg::TIME_W-1:0]      w_age;
    logic [arpc_pkg::TIME_W:0]        w_stamp_eff;
    logic                             w_ip_eq;
    logic                             w_wr_me;

    assign w_age       = i_req.now_ms - r_stamp;
    assign w_ip_eq     = r_valid && (r_ip == i_req.ip_addr);
    assign w_stamp_eff = r_valid ? {1'b0, r_stamp} : '0;
    assign w_wr_me     = i_wr.en && (i_wr.slot == arpc_pkg::SLOT_W'(CELL_IDX));

    always_comb begin
        n_carry = i_carry;
        if (!i_carry.done) begin
            if (i_req.req_type == arpc_pkg::REQ_RESOLVE) begin
                if (w_ip_eq &&
                    (w_age < {{(arpc_pkg::TIME_W-arpc_pkg::CFG_W){1'b0}}, i_lifetime})) begin
                    n_carry.done = 1'b1;
                    n_carry.hit  = 1'b1;
                    n_carry.slot = arpc_pkg::SLOT_W'(CELL_IDX);
                    n_carry.mac  = r_mac;
                end
            end else begin
                if (w_ip_eq) begin
                    n_carry.done = 1'b1;
                    n_carry.slot = arpc_pkg::SLOT_W'(CELL_IDX);
                end else if (w_stamp_eff < i_carry.oldest) begin
                    n_carry.oldest = w_stamp_eff;
                    n_carry.slot   = arpc_pkg::SLOT_W'(CELL_IDX);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_wr_me) begin
            r_valid <= 1'b1;
        end
        if (w_wr_me) begin
            r_ip    <= i_wr.ip;
            r_mac   <= i_wr.mac;
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_carry = r_carry;

endmodule

>>> rtl/core/arp_cache_with_aging_top.sv
// ----------------------------------------------------------------------------
// arp_cache_with_aging_top
// Address-resolution cache with entry aging and request rate limiting.
// ----------------------------------------------------------------------------
// Each request is taken in the idle state and ends in a registered
// response. The lookup walks a chain of ENTRIES cells, one cell per cycle.
// Each cell registers the running search result (hit, matching or oldest
// slot, oldest stamp) before handing it on. A finish state then settles
// the response, writes the chosen entry for a learn request and the
// request-throttle record for a sent request, and waits while a stalled
// response still holds the output. The control then returns to idle
// before it takes the next request. A new request is taken once the
// previous one has its response registered, even while that response is
// still stalled at the output. Entry valid bits clear at reset, so no warm-up pass is needed.
module arp_cache_with_aging_top #(
    parameter int ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [arpc_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  arpc_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output arpc_pkg::t_out_rsp                o_out_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                            r_state;
    logic [IDX_W-1:0]                  r_cnt;
    arpc_pkg::t_in_req                 r_req;
    logic [arpc_pkg::CFG_W-1:0]        r_lifetime;
    logic [arpc_pkg::CFG_W-1:0]        r_retry;
    logic [arpc_pkg::IP_W-1:0]         r_last_ip;
    logic [arpc_pkg::TIME_W-1:0]       r_last_time;
    logic                              r_out_valid;
    arpc_pkg::t_out_rsp                r_out_rsp;

    arpc_pkg::t_carry                  w_carry [ENTRIES+1];
    arpc_pkg::t_carry                  w_res;
    arpc_pkg::t_wr                     w_wr;
    arpc_pkg::t_out_rsp                w_rsp;
    logic                              w_out_free;
    logic                              w_finish;
    logic                              w_throttled;
    logic                              w_send;
    logic [arpc_pkg::TIME_W-1:0]       w_req_age;

    always_comb begin
        w_carry[0]        = '0;
        w_carry[0].oldest = '1;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (r_req),
            .i_lifetime (r_lifetime),
            .i_carry    (w_carry[g]),
            .o_carry    (w_carry[g+1]),
            .i_wr       (w_wr)
        );
    end

    assign w_res      = w_carry[ENTRIES];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == ST_FINISH) && w_out_free;

    assign w_req_age   = r_req.now_ms - r_last_time;
    assign w_throttled = (r_last_ip == r_req.ip_addr) && (r_last_time != '0) &&
        (w_req_age < {{(arpc_pkg::TIME_W-arpc_pkg::CFG_W){1'b0}}, r_retry});
    assign w_send = (r_req.req_type == arpc_pkg::REQ_RESOLVE) && !w_res.hit && !w_throttled;

    always_comb begin
        w_wr       = '0;
        w_wr.en    = w_finish && (r_req.req_type == arpc_pkg::REQ_LEARN);
        w_wr.slot  = w_res.slot;
        w_wr.ip    = r_req.ip_addr;
        w_wr.mac   = r_req.mac_addr;
        w_wr.stamp = r_req.now_ms;

        w_rsp = '0;
        if (r_req.req_type == arpc_pkg::REQ_LEARN) begin
            w_rsp.slot = w_res.slot[arpc_pkg::OUT_SLOT_W-1:0];
        end else if (w_res.hit) begin
            w_rsp.hit     = 1'b1;
            w_rsp.mac_out = w_res.mac;
            w_rsp.slot    = w_res.slot[arpc_pkg::OUT_SLOT_W-1:0];
        end else begin
            w_rsp.send_request = w_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_lifetime  <= arpc_pkg::LIFETIME_RST;
            r_retry     <= arpc_pkg::RETRY_RST;
            r_last_ip   <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == arpc_pkg::CFG_LIFETIME)) begin
                r_lifetime <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == arpc_pkg::CFG_RETRY)) begin
                r_retry <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(ENTRIES - 1)) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (w_send) begin
                            r_last_ip   <= r_req.ip_addr;
                            r_last_time <= (r_req.now_ms != '0) ? r_req.now_ms
                                                                : arpc_pkg::TIME_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        // payload registers
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (w_finish) begin
            r_out_rsp <= w_rsp;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
